// ===== rtl/http_chunked_body_decoder_macros.svh =====
// assertion helpers for the chunked body decoder
// both expect clk_i and rst_ni in the scope of the use
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// same-cycle implication
`define HCBD_ASSERT_SAME(label, lhs, rhs) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (lhs) |-> (rhs)) \
    else $error("hcbd same-cycle check failed");

// next-cycle implication
`define HCBD_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (lhs) |=> (rhs)) \
    else $error("hcbd next-cycle check failed");

`endif

// ===== rtl/hcbd_pkg.sv =====
package hcbd_pkg;

  // parser phase
  typedef enum logic [3:0] {
    PH_SIZE    = 4'd0,
    PH_EXT     = 4'd1,
    PH_SIZE_LF = 4'd2,
    PH_DATA    = 4'd3,
    PH_DATA_CR = 4'd4,
    PH_DATA_LF = 4'd5,
    PH_END_CR  = 4'd6,
    PH_END_LF  = 4'd7,
    PH_DONE    = 4'd8,
    PH_ERR1    = 4'd9,
    PH_ERR2    = 4'd10,
    PH_ERR3    = 4'd11
  } phase_e;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_NO_DIGIT = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [1:0] ERR_NO_CRLF  = 2'd3;

  // framing bytes
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // one result word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       body_end;
    logic [1:0] error_code;
  } result_t;

endpackage

// ===== rtl/http_chunked_body_decoder.sv =====
// a byte accepted into the input register loads its result word, if any, into the
// result register when it advances, and the receiver takes the word from there
// throughput: one byte per cycle unless the full result slot stalls; phase and size
// counter update together; bytes with no result (size digits, framing, post-end) advance
// reset: asynchronous active low, clears phase, size counter, digit flag and valid flags
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       body_end_o,
  output logic [1:0] error_code_o
);
  import hcbd_pkg::*;
  `include "http_chunked_body_decoder_macros.svh"

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_free;
  logic       advance;

  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && !in_stall_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_byte_q <= in_byte_i;
  end

  // parser state
  phase_e               phase_q, phase_d;
  logic [SIZE_BITS-1:0] remaining_q, remaining_d;
  logic                 digit_seen_q, digit_seen_d;
  logic                 emit;
  result_t              step_res;
  result_t              out_res;

  hcbd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .phase_i     (phase_q),
    .remaining_i (remaining_q),
    .digit_seen_i(digit_seen_q),
    .byte_i      (in_byte_q),
    .phase_o     (phase_d),
    .remaining_o (remaining_d),
    .digit_seen_o(digit_seen_d),
    .emit_o      (emit),
    .res_o       (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SIZE;
      remaining_q  <= '0;
      digit_seen_q <= 1'b0;
    end else if (advance) begin
      phase_q      <= phase_d;
      remaining_q  <= remaining_d;
      digit_seen_q <= digit_seen_d;
    end
  end

  // result register
  hcbd_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && emit),
    .res_i      (step_res),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (out_res)
  );

  assign data_byte_o  = out_res.data_byte;
  assign body_end_o   = out_res.body_end;
  assign error_code_o = out_res.error_code;

  // checks
  `HCBD_ASSERT_SAME(a_err_word_clean, out_valid_o && error_code_o != ERR_NONE,
                    data_byte_o == 8'd0 && !body_end_o)
  `HCBD_ASSERT_NEXT(a_err_sticky,
                    phase_q == PH_ERR1 || phase_q == PH_ERR2 || phase_q == PH_ERR3,
                    $stable(phase_q))
  `HCBD_ASSERT_NEXT(a_done_sticky, phase_q == PH_DONE, phase_q == PH_DONE)
  `HCBD_ASSERT_NEXT(a_end_then_done, out_valid_o && body_end_o, phase_q == PH_DONE)

endmodule

// ===== rtl/hcbd_step.sv =====
module hcbd_step #(
  parameter int SIZE_BITS = 32
) (
  input  hcbd_pkg::phase_e        phase_i,
  input  logic [SIZE_BITS-1:0]    remaining_i,
  input  logic                    digit_seen_i,
  input  logic [7:0]              byte_i,
  output hcbd_pkg::phase_e        phase_o,
  output logic [SIZE_BITS-1:0]    remaining_o,
  output logic                    digit_seen_o,
  output logic                    emit_o,
  output hcbd_pkg::result_t       res_o
);
  import hcbd_pkg::*;

  // hex digit decode
  logic       hex_ok;
  logic [3:0] hex_val;
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      hex_val = 4'(byte_i - 8'h30);
    end else if (byte_i >= 8'h41 && byte_i <= 8'h46) begin
      hex_val = 4'(byte_i - 8'h41 + 8'd10);
    end else if (byte_i >= 8'h61 && byte_i <= 8'h66) begin
      hex_val = 4'(byte_i - 8'h61 + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  logic                 top_nibble_busy;
  logic [SIZE_BITS-1:0] remaining_dec;
  assign top_nibble_busy = |remaining_i[SIZE_BITS-1 -: 4];
  assign remaining_dec   = remaining_i - SIZE_BITS'(1);

  // next phase
  always_comb begin
    phase_o = phase_i;
    unique case (phase_i)
      PH_SIZE: begin
        if (hex_ok) begin
          if (top_nibble_busy) phase_o = PH_ERR2;
        end else if (!digit_seen_i) begin
          phase_o = PH_ERR1;
        end else begin
          phase_o = (byte_i == CHAR_CR) ? PH_SIZE_LF : PH_EXT;
        end
      end
      PH_EXT: if (byte_i == CHAR_CR) phase_o = PH_SIZE_LF;
      PH_SIZE_LF: begin
        if (byte_i == CHAR_LF) begin
          phase_o = (remaining_i == '0) ? PH_END_CR : PH_DATA;
        end else if (byte_i != CHAR_CR) begin
          phase_o = PH_EXT;
        end
      end
      PH_DATA:    if (remaining_dec == '0) phase_o = PH_DATA_CR;
      PH_DATA_CR: phase_o = (byte_i == CHAR_CR) ? PH_DATA_LF : PH_ERR3;
      PH_DATA_LF: phase_o = (byte_i == CHAR_LF) ? PH_SIZE : PH_ERR3;
      PH_END_CR:  if (byte_i == CHAR_CR) phase_o = PH_END_LF;
      PH_END_LF: begin
        if (byte_i == CHAR_LF) begin
          phase_o = PH_DONE;
        end else if (byte_i != CHAR_CR) begin
          phase_o = PH_END_CR;
        end
      end
      default: phase_o = phase_i;
    endcase
  end

  // counter, digit flag and result word
  always_comb begin
    remaining_o  = remaining_i;
    digit_seen_o = digit_seen_i;
    emit_o       = 1'b0;
    res_o        = '{data_byte: 8'd0, body_end: 1'b0, error_code: ERR_NONE};
    unique case (phase_i)
      PH_SIZE: begin
        if (hex_ok) begin
          if (top_nibble_busy) begin
            emit_o           = 1'b1;
            res_o.error_code = ERR_OVERFLOW;
          end else begin
            remaining_o  = {remaining_i[SIZE_BITS-5:0], hex_val};
            digit_seen_o = 1'b1;
          end
        end else if (!digit_seen_i) begin
          emit_o           = 1'b1;
          res_o.error_code = ERR_NO_DIGIT;
        end
      end
      PH_DATA: begin
        remaining_o     = remaining_dec;
        emit_o          = 1'b1;
        res_o.data_byte = byte_i;
      end
      PH_DATA_CR: begin
        if (byte_i != CHAR_CR) begin
          emit_o           = 1'b1;
          res_o.error_code = ERR_NO_CRLF;
        end
      end
      PH_DATA_LF: begin
        if (byte_i != CHAR_LF) begin
          emit_o           = 1'b1;
          res_o.error_code = ERR_NO_CRLF;
        end else begin
          remaining_o  = '0;
          digit_seen_o = 1'b0;
        end
      end
      PH_END_LF: begin
        if (byte_i == CHAR_LF) begin
          emit_o         = 1'b1;
          res_o.body_end = 1'b1;
        end
      end
      PH_ERR1: begin
        emit_o           = 1'b1;
        res_o.error_code = ERR_NO_DIGIT;
      end
      PH_ERR2: begin
        emit_o           = 1'b1;
        res_o.error_code = ERR_OVERFLOW;
      end
      PH_ERR3: begin
        emit_o           = 1'b1;
        res_o.error_code = ERR_NO_CRLF;
      end
      default: emit_o = 1'b0;
    endcase
  end

endmodule

// ===== rtl/hcbd_out_reg.sv =====
module hcbd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hcbd_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hcbd_pkg::result_t res_o
);
  import hcbd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // slot is free when empty or being taken this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== verif/tb_http_chunked_body_decoder.sv =====
import hcbd_pkg::*;

// hex digit value of an ascii byte, -1 when not a hex digit
function automatic int hex_val(logic [7:0] c);
  if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
  if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
  if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
  return -1;
endfunction

// chunked body parser mirror plus queue of expected result words
class chunk_scoreboard #(int SZ = 32);
  phase_e        ph;
  logic [SZ-1:0] remaining;
  bit            digit_seen;
  result_t       expected_q[$];
  int            errors;

  function new();
    ph         = PH_SIZE;
    remaining  = '0;
    digit_seen = 1'b0;
    errors     = 0;
  endfunction

  function int pending_count();
    return expected_q.size();
  endfunction

  function void push_word(logic [7:0] data, logic ends, logic [1:0] err);
    result_t w;
    w.data_byte  = data;
    w.body_end   = ends;
    w.error_code = err;
    expected_q.push_back(w);
  endfunction

  // errors are sticky: move to the matching error phase
  function void push_error(logic [1:0] err);
    case (err)
      ERR_NO_DIGIT: ph = PH_ERR1;
      ERR_OVERFLOW: ph = PH_ERR2;
      default:      ph = PH_ERR3;
    endcase
    push_word(8'h00, 1'b0, err);
  endfunction

  // advance the parser by one accepted input word
  function void note_byte(logic [7:0] b);
    int h;
    h = hex_val(b);
    case (ph)
      PH_SIZE: begin
        if (h >= 0) begin
          if (remaining[SZ-1 -: 4] != 4'h0) begin
            push_error(ERR_OVERFLOW);
          end else begin
            remaining  = {remaining[SZ-5:0], 4'(h)};
            digit_seen = 1'b1;
          end
        end else if (!digit_seen) begin
          push_error(ERR_NO_DIGIT);
        end else begin
          ph = (b == CHAR_CR) ? PH_SIZE_LF : PH_EXT;
        end
      end
      PH_EXT: begin
        if (b == CHAR_CR) ph = PH_SIZE_LF;
      end
      PH_SIZE_LF: begin
        if (b == CHAR_LF) ph = (remaining == '0) ? PH_END_CR : PH_DATA;
        else if (b != CHAR_CR) ph = PH_EXT;
      end
      PH_DATA: begin
        remaining = remaining - 1'b1;
        if (remaining == '0) ph = PH_DATA_CR;
        push_word(b, 1'b0, ERR_NONE);
      end
      PH_DATA_CR: begin
        if (b != CHAR_CR) push_error(ERR_NO_CRLF);
        else ph = PH_DATA_LF;
      end
      PH_DATA_LF: begin
        if (b != CHAR_LF) begin
          push_error(ERR_NO_CRLF);
        end else begin
          ph         = PH_SIZE;
          remaining  = '0;
          digit_seen = 1'b0;
        end
      end
      PH_END_CR: begin
        if (b == CHAR_CR) ph = PH_END_LF;
      end
      PH_END_LF: begin
        if (b == CHAR_LF) begin
          ph = PH_DONE;
          push_word(8'h00, 1'b1, ERR_NONE);
        end else if (b != CHAR_CR) begin
          ph = PH_END_CR;
        end
      end
      PH_ERR1: push_word(8'h00, 1'b0, ERR_NO_DIGIT);
      PH_ERR2: push_word(8'h00, 1'b0, ERR_OVERFLOW);
      PH_ERR3: push_word(8'h00, 1'b0, ERR_NO_CRLF);
      default: ;
    endcase
  endfunction

  // compare one accepted result word with the oldest expectation
  function void check_word(result_t got);
    result_t exp_w;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result word, actual %h", $realtime, got);
      errors++;
      return;
    end
    exp_w = expected_q.pop_front();
    if (got.data_byte !== exp_w.data_byte) begin
      $display("%0t: data_byte expected %h actual %h", $realtime,
               exp_w.data_byte, got.data_byte);
      errors++;
    end
    if (got.body_end !== exp_w.body_end) begin
      $display("%0t: body_end expected %b actual %b", $realtime,
               exp_w.body_end, got.body_end);
      errors++;
    end
    if (got.error_code !== exp_w.error_code) begin
      $display("%0t: error_code expected %h actual %h", $realtime,
               exp_w.error_code, got.error_code);
      errors++;
    end
  endfunction
endclass

module tb_http_chunked_body_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIZE_BITS    = 32;
  localparam int RANDOM_ITEMS = 1850;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] data_byte_o;
  logic       body_end_o;
  logic [1:0] error_code_o;

  chunk_scoreboard #(SIZE_BITS) sb;

  int idle_in_pct;
  int idle_out_pct;
  int bytes_sent;
  bit hold_req;

  http_chunked_body_decoder #(.SIZE_BITS(SIZE_BITS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_byte_o (data_byte_o),
    .body_end_o  (body_end_o),
    .error_code_o(error_code_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // result side: check accepted words, then pick next stall
  initial begin
    int hold_left;
    result_t got;
    hold_left   = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.data_byte  = data_byte_o;
        got.body_end   = body_end_o;
        got.error_code = error_code_o;
        sb.check_word(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < idle_out_pct);
      end
    end
  end

  // offer one word, wait for acceptance
  task automatic send_byte(input logic [7:0] b);
    while (idle_in_pct != 0 && $urandom_range(0, 99) < idle_in_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] hex_char(input int d);
    if (d < 10) return 8'h30 + 8'(d);
    if ($urandom_range(0, 1) != 0) return 8'h41 + 8'(d - 10);
    return 8'h61 + 8'(d - 10);
  endfunction

  function automatic logic [7:0] rand_hex_char();
    return hex_char($urandom_range(0, 15));
  endfunction

  // random byte that is neither a hex digit nor CR
  function automatic logic [7:0] rand_nonhex();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (hex_val(c) >= 0 || c == CHAR_CR) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // random byte other than CR and LF
  function automatic logic [7:0] rand_junk();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CHAR_CR || c == CHAR_LF) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // size line: optional leading zeros, hex digits, optional extension, CR (sometimes twice), LF
  task automatic send_size_line(input int size);
    int ndig;
    int i;
    ndig = 1;
    while ((size >> (4 * ndig)) != 0) ndig++;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'h30);
    end
    for (i = ndig - 1; i >= 0; i--) send_byte(hex_char((size >> (4 * i)) & 15));
    if ($urandom_range(0, 2) == 0) begin
      send_byte(($urandom_range(0, 1) != 0) ? CHAR_SEMI : rand_nonhex());
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 4))
          0: send_byte(rand_hex_char());
          1: begin
            // lone CR inside the extension falls back to skipping
            send_byte(CHAR_CR);
            send_byte(rand_junk());
          end
          default: send_byte(rand_nonhex());
        endcase
      end
    end
    send_byte(CHAR_CR);
    if ($urandom_range(0, 5) == 0) send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  // full well-formed chunk with random content
  task automatic send_chunk(input int size);
    send_size_line(size);
    repeat (size) send_byte(8'($urandom_range(0, 255)));
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  function automatic int rand_size();
    case ($urandom_range(0, 15))
      0:       return $urandom_range(65, 511);
      1, 2:    return $urandom_range(17, 64);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  // finish the body: end marker or one of the errors, then trailing noise
  task automatic send_ending(input int kind);
    int n;
    case (kind)
      0: begin
        send_size_line(0);
        // noise on the last line, lone CRs included
        repeat ($urandom_range(0, 3)) send_byte(rand_junk());
        send_byte(CHAR_CR);
        send_byte(rand_junk());
        send_byte(CHAR_CR);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
      end
      1: begin
        send_byte(($urandom_range(0, 1) != 0) ? CHAR_CR : rand_nonhex());
      end
      2: begin
        repeat ($urandom_range(0, 3)) send_byte(8'h30);
        send_byte(hex_char($urandom_range(1, 15)));
        repeat (8) send_byte(rand_hex_char());
      end
      default: begin
        n = $urandom_range(1, 4);
        send_size_line(n);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) != 0) begin
          send_byte(CHAR_CR);
          n = $urandom_range(0, 255);
          while (n == CHAR_LF) n = $urandom_range(0, 255);
          send_byte(8'(n));
        end else begin
          n = $urandom_range(0, 255);
          while (n == CHAR_CR) n = $urandom_range(0, 255);
          send_byte(8'(n));
        end
      end
    endcase
    repeat (20) send_byte(8'($urandom_range(0, 255)));
  endtask

  // stimulus
  initial begin
    int mode;
    int target;
    sb           = new();
    idle_in_pct  = 0;
    idle_out_pct = 0;
    bytes_sent   = 0;
    hold_req     = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_byte_i   <= 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: leading zeros, hex in extension, CR CR and CR junk on a size line
    send_byte(8'h30); send_byte(8'h30); send_byte(8'h32);
    send_byte(CHAR_SEMI); send_byte(8'h46);
    send_byte(CHAR_CR); send_byte(CHAR_CR); send_byte(8'h78);
    send_byte(CHAR_CR); send_byte(CHAR_LF);
    send_byte(8'h00); send_byte(8'hFF);
    send_byte(CHAR_CR); send_byte(CHAR_LF);
    // many leading zeros never overflow; CR as a data word
    repeat (9) send_byte(8'h30);
    send_byte(8'h31); send_byte(CHAR_CR); send_byte(CHAR_LF);
    send_byte(CHAR_CR);
    send_byte(CHAR_CR); send_byte(CHAR_LF);

    // random chunks over four idling phases
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_in_pct = 0;  idle_out_pct = 0;  end
        1: begin idle_in_pct = 49; idle_out_pct = 0;  end
        2: begin idle_in_pct = 0;  idle_out_pct = 49; end
        default: begin idle_in_pct = 22; idle_out_pct = 22; end
      endcase
      target = bytes_sent + RANDOM_ITEMS / 4;
      if (mode == 0) begin
        // long receiver hold while the sender keeps pushing data
        hold_req = 1'b1;
        send_chunk(300);
      end
      if (mode == 2) begin
        in_valid_i <= 1'b0;
        while (sb.pending_count() != 0) @(posedge clk_i);
      end
      while (bytes_sent < target) send_chunk(rand_size());
    end

    send_ending($urandom_range(0, 3));
    in_valid_i <= 1'b0;

    // drain
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
